// File: design/prmc_pkg.sv
// prmc_pkg: shared codes, parser phases and controller/datapath command and status types
// for the process range map cache. No dependencies.
package prmc_pkg;

  localparam logic [2:0] MODE_LOOKUP = 3'd0;
  localparam logic [2:0] MODE_LOAD   = 3'd1;
  localparam logic [2:0] MODE_BYTE   = 3'd2;
  localparam logic [2:0] MODE_INVAL  = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [1:0] KIND_HIT    = 2'd0;
  localparam logic [1:0] KIND_MISS   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BRACKET = 8'h5B;

  typedef enum logic [13:0] {
    PH_LSTART   = 14'b00000000000001,
    PH_START    = 14'b00000000000010,
    PH_END      = 14'b00000000000100,
    PH_PERM_WS  = 14'b00000000001000,
    PH_PERM_TOK = 14'b00000000010000,
    PH_OFF_WS   = 14'b00000000100000,
    PH_OFF_HEX  = 14'b00000001000000,
    PH_DEV_WS   = 14'b00000010000000,
    PH_DEV_TOK  = 14'b00000100000000,
    PH_INO_WS   = 14'b00001000000000,
    PH_INO_TOK  = 14'b00010000000000,
    PH_PATH_WS  = 14'b00100000000000,
    PH_NAME     = 14'b01000000000000,
    PH_DROP     = 14'b10000000000000
  } phase_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic scan_step;
    logic stamp_hit;
    logic apply_load;
    logic inval;
    logic clear_all;
    logic rng_rd;
    logic ent_step;
    logic hit_cap;
    logic name_rd;
    logic k_step;
    logic byte_do;
    logic emit_miss;
    logic emit_reject;
    logic emit_hit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] mode;
    logic       pid_zero;
    logic       scan_last;
    logic       found;
    logic       count_pos;
    logic       hit;
    logic       ent_last;
    logic       name_last;
  } st_t;

  // {valid, value} of a hex digit
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
      return {1'b1, v[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// File: design/prmc_ctrl.sv
// prmc_ctrl: sequencing state machine of the range map cache.
// Depends on prmc_pkg (cmd_t, st_t, mode codes).
module prmc_ctrl import prmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] mode_i,
  input  st_t        st_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SCAN     = 9'b000000010,
    S_DECIDE   = 9'b000000100,
    S_RNG_RD   = 9'b000001000,
    S_RNG_CHK  = 9'b000010000,
    S_NAME_RD  = 9'b000100000,
    S_NAME_OUT = 9'b001000000,
    S_BYTE     = 9'b010000000,
    S_CLEAR    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          unique case (mode_i)
            MODE_LOOKUP, MODE_LOAD, MODE_INVAL: state_d = S_SCAN;
            MODE_BYTE:  state_d = S_BYTE;
            MODE_CLEAR: state_d = S_CLEAR;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (st_i.scan_last) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        unique case (st_i.mode)
          MODE_LOOKUP: begin
            if (!st_i.pid_zero && st_i.found && st_i.count_pos) begin
              cmd_o.stamp_hit = 1'b1;
              state_d = S_RNG_RD;
            end else begin
              cmd_o.emit_miss = 1'b1;
            end
          end
          MODE_LOAD: begin
            if (st_i.pid_zero) cmd_o.emit_reject = 1'b1;
            else cmd_o.apply_load = 1'b1;
          end
          default: cmd_o.inval = 1'b1;
        endcase
      end
      S_RNG_RD: begin
        cmd_o.rng_rd = 1'b1;
        state_d = S_RNG_CHK;
      end
      S_RNG_CHK: begin
        if (st_i.hit) begin
          cmd_o.hit_cap = 1'b1;
          state_d = S_NAME_RD;
        end else if (st_i.ent_last) begin
          cmd_o.emit_miss = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.ent_step = 1'b1;
          state_d = S_RNG_RD;
        end
      end
      S_NAME_RD: begin
        cmd_o.name_rd = 1'b1;
        state_d = S_NAME_OUT;
      end
      S_NAME_OUT: begin
        cmd_o.emit_hit = 1'b1;
        if (st_i.name_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.k_step = 1'b1;
          state_d = S_NAME_RD;
        end
      end
      S_BYTE: begin
        cmd_o.byte_do = 1'b1;
        state_d = S_IDLE;
      end
      S_CLEAR: begin
        cmd_o.clear_all = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: design/prmc_dp.sv
// prmc_dp: slot table, map text parser, range and name memories, result register.
// Depends on prmc_pkg; driven by prmc_ctrl commands.
module prmc_dp import prmc_pkg::*; #(
  parameter int PROC_SLOTS      = 8,
  parameter int RANGES_PER_PROC = 32,
  parameter int NAME_LEN        = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  mode_i,
  input  logic [21:0] proc_id_i,
  input  logic [63:0] query_addr_i,
  input  logic [7:0]  text_byte_i,
  input  logic        text_last_i,
  input  cmd_t        cmd_i,
  output st_t         st_o,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [63:0] mapped_offset_o,
  output logic [7:0]  name_char_o,
  output logic [5:0]  stored_count_o,
  output logic        run_last_o
);

  localparam int S  = PROC_SLOTS;
  localparam int R  = RANGES_PER_PROC;
  localparam int E  = S * R;
  localparam int SW = (S > 1) ? $clog2(S) : 1;
  localparam int RW = (R > 1) ? $clog2(R) : 1;
  localparam int CW = $clog2(R + 1);
  localparam int EW = (E > 1) ? $clog2(E) : 1;
  localparam int NW = $clog2(E * NAME_LEN);
  localparam int LW = $clog2(NAME_LEN);

  typedef struct packed {
    logic [63:0]   lo;
    logic [63:0]   hi;
    logic [63:0]   foff;
    logic [LW-1:0] len;
  } rng_t;

  // latched transaction
  logic [2:0]  mode_q;
  logic [21:0] pid_q;
  logic [63:0] addr_q;
  logic [7:0]  byte_q;
  logic        last_q;

  // slot table
  logic [21:0]   slot_proc_q  [S];
  logic [CW-1:0] slot_count_q [S];
  logic [63:0]   slot_stamp_q [S];
  logic [63:0]   stamp_ctr_q;

  // slot scan
  logic [SW-1:0] scan_idx_q, match_idx_q, empty_idx_q, min_idx_q;
  logic          found_q, empty_found_q;
  logic [CW-1:0] match_count_q;
  logic [63:0]   min_stamp_q;

  // lookup
  logic [RW-1:0] ent_q;
  rng_t          rng_q;
  logic [63:0]   off_q;
  logic [LW-1:0] len_q, k_q;
  logic [EW-1:0] hit_ent_q;
  logic [7:0]    name_q;

  // parser
  phase_e        phase_q, ph_n;
  logic [63:0]   accum_q, acc_n, lo_q, lo_n, hi_q, hi_n, foff_q, off_n;
  logic [LW-1:0] nlen_q, len_n;
  logic [SW-1:0] load_slot_q;
  logic [CW-1:0] load_count_q;
  logic          load_active_q;

  // result register
  logic        out_valid_q, out_last_q;
  logic [1:0]  out_kind_q;
  logic [63:0] out_off_q;
  logic [7:0]  out_char_q;
  logic [5:0]  out_cnt_q;

  rng_t       rng_mem  [E];
  logic [7:0] name_mem [E * NAME_LEN];

  // ---- slot scan ----
  logic [21:0]   cur_proc;
  logic [63:0]   cur_stamp;
  logic [SW-1:0] pick;
  assign cur_proc  = slot_proc_q[scan_idx_q];
  assign cur_stamp = slot_stamp_q[scan_idx_q];
  assign pick = found_q ? match_idx_q : (empty_found_q ? empty_idx_q : min_idx_q);

  // ---- lookup addressing ----
  logic [EW-1:0] rd_ent;
  logic [NW-1:0] name_ra;
  logic          hit;
  assign rd_ent  = EW'(match_idx_q) * EW'(R) + EW'(ent_q);
  assign name_ra = NW'(hit_ent_q) * NW'(NAME_LEN) + NW'(k_q);
  assign hit     = (addr_q >= rng_q.lo) && (addr_q < rng_q.hi);

  // ---- parser step ----
  logic [4:0]    hx;
  logic          is_ws, is_nl, fed, end_now, commit, name_we;
  logic [CW-1:0] count_n;
  logic [EW-1:0] wr_ent;
  logic [NW-1:0] name_wa;
  logic [63:0]   acc_sh;

  assign hx     = hex_digit(byte_q);
  assign is_ws  = (byte_q == CH_SPACE) || (byte_q == CH_TAB);
  assign is_nl  = (byte_q == CH_NL) || (byte_q == CH_NUL);
  assign fed    = load_active_q && (load_count_q < CW'(R));
  assign acc_sh = {accum_q[59:0], hx[3:0]};
  assign wr_ent = EW'(load_slot_q) * EW'(R) + EW'(load_count_q[RW-1:0]);
  assign name_wa = NW'(wr_ent) * NW'(NAME_LEN) + NW'(nlen_q);

  always_comb begin
    ph_n    = phase_q;
    acc_n   = accum_q;
    lo_n    = lo_q;
    hi_n    = hi_q;
    off_n   = foff_q;
    len_n   = nlen_q;
    name_we = 1'b0;
    if (fed && !is_nl) begin
      unique case (phase_q)
        PH_LSTART: begin
          len_n = '0;
          acc_n = '0;
          if (hx[4]) begin
            acc_n = {60'd0, hx[3:0]};
            ph_n  = PH_START;
          end else if (byte_q == CH_DASH) begin
            lo_n = '0;
            ph_n = PH_END;
          end else begin
            ph_n = PH_DROP;
          end
        end
        PH_START: begin
          if (hx[4]) begin
            acc_n = acc_sh;
          end else if (byte_q == CH_DASH) begin
            lo_n  = accum_q;
            acc_n = '0;
            ph_n  = PH_END;
          end else begin
            ph_n = PH_DROP;
          end
        end
        PH_END: begin
          if (hx[4]) begin
            acc_n = acc_sh;
          end else begin
            hi_n = accum_q;
            ph_n = is_ws ? PH_PERM_WS : PH_PERM_TOK;
          end
        end
        PH_PERM_WS:  if (!is_ws) ph_n = PH_PERM_TOK;
        PH_PERM_TOK: if (is_ws) ph_n = PH_OFF_WS;
        PH_OFF_WS: begin
          if (!is_ws) begin
            if (hx[4]) begin
              acc_n = {60'd0, hx[3:0]};
              ph_n  = PH_OFF_HEX;
            end else begin
              acc_n = '0;
              off_n = '0;
              ph_n  = PH_DEV_TOK;
            end
          end
        end
        PH_OFF_HEX: begin
          if (hx[4]) begin
            acc_n = acc_sh;
          end else begin
            off_n = accum_q;
            ph_n  = is_ws ? PH_DEV_WS : PH_DEV_TOK;
          end
        end
        PH_DEV_WS:   if (!is_ws) ph_n = PH_DEV_TOK;
        PH_DEV_TOK:  if (is_ws) ph_n = PH_INO_WS;
        PH_INO_WS:   if (!is_ws) ph_n = PH_INO_TOK;
        PH_INO_TOK:  if (is_ws) ph_n = PH_PATH_WS;
        PH_PATH_WS: begin
          if (!is_ws) begin
            if (byte_q != CH_SLASH && byte_q != CH_BRACKET) begin
              ph_n = PH_DROP;
            end else begin
              ph_n = PH_NAME;
              if (nlen_q < LW'(NAME_LEN - 1)) begin
                name_we = 1'b1;
                len_n   = nlen_q + 1'b1;
              end
            end
          end
        end
        PH_NAME: begin
          if (nlen_q < LW'(NAME_LEN - 1)) begin
            name_we = 1'b1;
            len_n   = nlen_q + 1'b1;
          end
        end
        PH_DROP: ph_n = PH_DROP;
        default: ph_n = phase_q;
      endcase
    end
  end

  assign end_now = load_active_q && ((fed && is_nl) || last_q);
  assign commit  = end_now && (ph_n == PH_NAME) && (lo_n < hi_n) &&
                   (load_count_q < CW'(R));
  assign count_n = load_count_q + CW'(commit);

  // ---- memories ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_do && commit) begin
      rng_mem[wr_ent] <= '{lo: lo_n, hi: hi_n, foff: off_n, len: len_n};
    end
    if (cmd_i.rng_rd) rng_q <= rng_mem[rd_ent];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_do && name_we) name_mem[name_wa] <= byte_q;
    if (cmd_i.name_rd) name_q <= name_mem[name_ra];
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      pid_q  <= proc_id_i;
      addr_q <= query_addr_i;
      byte_q <= text_byte_i;
      last_q <= text_last_i;
    end
    if (cmd_i.hit_cap) begin
      off_q     <= (addr_q - rng_q.lo) + rng_q.foff;
      len_q     <= rng_q.len;
      hit_ent_q <= rd_ent;
    end
    if (cmd_i.emit_hit) begin
      out_kind_q <= KIND_HIT;
      out_off_q  <= off_q;
      out_char_q <= (len_q == '0) ? 8'd0 : name_q;
      out_cnt_q  <= '0;
      out_last_q <= st_o.name_last;
    end else begin
      out_off_q  <= '0;
      out_char_q <= '0;
      out_last_q <= 1'b1;
      if (cmd_i.byte_do) begin
        out_kind_q <= KIND_DONE;
        out_cnt_q  <= 6'(count_n);
      end else begin
        out_kind_q <= cmd_i.emit_reject ? KIND_REJECT : KIND_MISS;
        out_cnt_q  <= '0;
      end
    end
  end

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < S; i++) begin
        slot_proc_q[i]  <= '0;
        slot_count_q[i] <= '0;
        slot_stamp_q[i] <= '0;
      end
      stamp_ctr_q   <= '0;
      scan_idx_q    <= '0;
      match_idx_q   <= '0;
      empty_idx_q   <= '0;
      min_idx_q     <= '0;
      found_q       <= 1'b0;
      empty_found_q <= 1'b0;
      match_count_q <= '0;
      min_stamp_q   <= '0;
      ent_q         <= '0;
      k_q           <= '0;
      phase_q       <= PH_LSTART;
      accum_q       <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      foff_q        <= '0;
      nlen_q        <= '0;
      load_slot_q   <= '0;
      load_count_q  <= '0;
      load_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit_miss || cmd_i.emit_reject || cmd_i.emit_hit ||
                     (cmd_i.byte_do && load_active_q && last_q);
      if (cmd_i.latch) begin
        scan_idx_q    <= '0;
        found_q       <= 1'b0;
        empty_found_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (!found_q && cur_proc == pid_q) begin
          found_q       <= 1'b1;
          match_idx_q   <= scan_idx_q;
          match_count_q <= slot_count_q[scan_idx_q];
        end
        if (!empty_found_q && cur_proc == '0) begin
          empty_found_q <= 1'b1;
          empty_idx_q   <= scan_idx_q;
        end
        if (scan_idx_q == '0 || cur_stamp < min_stamp_q) begin
          min_idx_q   <= scan_idx_q;
          min_stamp_q <= cur_stamp;
        end
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      if (cmd_i.stamp_hit) begin
        stamp_ctr_q               <= stamp_ctr_q + 64'd1;
        slot_stamp_q[match_idx_q] <= stamp_ctr_q + 64'd1;
        ent_q                     <= '0;
      end
      if (cmd_i.ent_step) ent_q <= ent_q + 1'b1;
      if (cmd_i.hit_cap) k_q <= '0;
      if (cmd_i.k_step) k_q <= k_q + 1'b1;
      if (cmd_i.apply_load) begin
        slot_proc_q[pick]  <= pid_q;
        slot_count_q[pick] <= '0;
        slot_stamp_q[pick] <= stamp_ctr_q + 64'd1;
        stamp_ctr_q        <= stamp_ctr_q + 64'd1;
        load_slot_q        <= pick;
        load_count_q       <= '0;
        load_active_q      <= 1'b1;
        phase_q            <= PH_LSTART;
        accum_q            <= '0;
        nlen_q             <= '0;
      end
      if (cmd_i.inval && found_q) begin
        slot_proc_q[match_idx_q]  <= '0;
        slot_count_q[match_idx_q] <= '0;
        if (load_slot_q == match_idx_q) load_active_q <= 1'b0;
      end
      if (cmd_i.clear_all) begin
        for (int i = 0; i < S; i++) begin
          slot_proc_q[i]  <= '0;
          slot_count_q[i] <= '0;
          slot_stamp_q[i] <= '0;
        end
        load_active_q <= 1'b0;
      end
      if (cmd_i.byte_do && load_active_q) begin
        phase_q      <= end_now ? PH_LSTART : ph_n;
        accum_q      <= end_now ? 64'd0 : acc_n;
        lo_q         <= lo_n;
        hi_q         <= hi_n;
        foff_q       <= off_n;
        nlen_q       <= len_n;
        load_count_q <= count_n;
        if (last_q) begin
          slot_count_q[load_slot_q] <= count_n;
          load_active_q             <= 1'b0;
        end
      end
    end
  end

  assign st_o.mode      = mode_q;
  assign st_o.pid_zero  = (pid_q == '0);
  assign st_o.scan_last = (scan_idx_q == SW'(S - 1));
  assign st_o.found     = found_q;
  assign st_o.count_pos = (match_count_q != '0);
  assign st_o.hit       = hit;
  assign st_o.ent_last  = ((CW'(ent_q) + 1'b1) == match_count_q);
  assign st_o.name_last = (len_q == '0) || (k_q == len_q - 1'b1);

  assign result_valid_o  = out_valid_q;
  assign kind_o          = out_kind_q;
  assign mapped_offset_o = out_off_q;
  assign name_char_o     = out_char_q;
  assign stored_count_o  = out_cnt_q;
  assign run_last_o      = out_last_q;

endmodule

// File: design/process_range_map_cache.sv
// process_range_map_cache: top level of the per-process range map cache.
// Depends on prmc_pkg, prmc_ctrl and prmc_dp.
//
//  channel   direction  handshake                     fields
//  command   in         start_i while busy_o is low   mode, proc_id, query_addr,
//                                                     text_byte, text_last
//  result    out        result_valid_o, one cycle     kind, mapped_offset,
//                                                     name_char, stored_count,
//                                                     run_last
//
// A load byte and clear all are each applied from a single state. Load start,
// invalidate and the slot part of a lookup scan one slot of the table per cycle.
// A lookup then checks each range after a registered range memory read and sends
// each name byte after a registered name memory read.
// Reset clears the slot table and parser at once; the range and name memories
// are not cleared and are only read where the current load wrote them.
// The receiver cannot stall: each result is on the ports for one cycle.
module process_range_map_cache import prmc_pkg::*; #(
  parameter int PROC_SLOTS      = 8,
  parameter int RANGES_PER_PROC = 32,
  parameter int NAME_LEN        = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic [21:0] proc_id_i,
  input  logic [63:0] query_addr_i,
  input  logic [7:0]  text_byte_i,
  input  logic        text_last_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [63:0] mapped_offset_o,
  output logic [7:0]  name_char_o,
  output logic [5:0]  stored_count_o,
  output logic        run_last_o
);

  cmd_t cmd;
  st_t  st;

  // controller sequences every transaction; datapath holds all cache, parser and result state
  prmc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .st_i    (st),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  prmc_dp #(
    .PROC_SLOTS      (PROC_SLOTS),
    .RANGES_PER_PROC (RANGES_PER_PROC),
    .NAME_LEN        (NAME_LEN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_i),
    .proc_id_i       (proc_id_i),
    .query_addr_i    (query_addr_i),
    .text_byte_i     (text_byte_i),
    .text_last_i     (text_last_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .result_valid_o  (result_valid_o),
    .kind_o          (kind_o),
    .mapped_offset_o (mapped_offset_o),
    .name_char_o     (name_char_o),
    .stored_count_o  (stored_count_o),
    .run_last_o      (run_last_o)
  );

endmodule

// File: design/prmc_checker.sv
// prmc_checker: port-level assertions for process_range_map_cache, bound in.
// Depends on prmc_pkg (kind codes).
module prmc_checker import prmc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy_o,
  input logic        result_valid_o,
  input logic [1:0]  kind_o,
  input logic [63:0] mapped_offset_o,
  input logic [7:0]  name_char_o,
  input logic [5:0]  stored_count_o,
  input logic        run_last_o
);

  // only name bytes come in runs
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o != KIND_HIT |-> run_last_o)
    else $error("non-hit result without run_last");

  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o != KIND_DONE |-> stored_count_o == 6'd0)
    else $error("stored_count set outside load done");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o != KIND_HIT |-> mapped_offset_o == 64'd0 && name_char_o == 8'd0)
    else $error("payload set on non-hit result");

  a_run_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !run_last_o |-> ##2 result_valid_o && kind_o == KIND_HIT &&
      mapped_offset_o == $past(mapped_offset_o, 2))
    else $error("name run broken");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !run_last_o |-> busy_o)
    else $error("idle in the middle of a name run");

endmodule

bind process_range_map_cache prmc_checker u_prmc_checker (.*);
